>>> hw/rtl/cv_step_sequencer_top_macros.svh
// Assertion macros used by the step sequencer checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef CV_STEP_SEQUENCER_TOP_MACROS_SVH
`define CV_STEP_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cvs_pkg.sv
// Shared types, codes, widths and the tempo period table for the step sequencer.
// No dependencies.
package cvs_pkg;

    localparam int STEPS_DEFAULT = 32;
    localparam int SAMPLE_BITS   = 10;
    localparam int MODE_BITS     = 2;
    localparam int KIND_BITS     = 2;
    localparam int LED_BITS      = 4;
    localparam int PERIOD_BITS   = 10;
    localparam int POS_OUT_BITS  = 5;
    localparam int QUOT_BITS     = 4;

    // tempo / 100 as (tempo * 41) >> 12, exact for 10-bit tempo values
    localparam int TEMPO_RECIP       = 41;
    localparam int TEMPO_RECIP_BITS  = 6;
    localparam int TEMPO_RECIP_SHIFT = 12;
    localparam int TEMPO_PROD_BITS   = SAMPLE_BITS + TEMPO_RECIP_BITS;

    localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(5);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(819);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [MODE_BITS-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_RECORD  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_REPLACE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_PLAY    = 2'd3;

    localparam logic [KIND_BITS-1:0] KIND_TEMPO = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_STEP  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic                   command;
        logic [MODE_BITS-1:0]   mode;
        logic [SAMPLE_BITS-1:0] pitch_sample;
        logic [SAMPLE_BITS-1:0] tempo_sample;
    } item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [SAMPLE_BITS-1:0]  dac_value;
        logic [LED_BITS-1:0]     step_leds;
        logic [PERIOD_BITS-1:0]  tick_period;
        logic [SAMPLE_BITS-1:0]  next_pitch;
        logic [POS_OUT_BITS-1:0] step_position;
    } result_t;

    typedef logic [SAMPLE_BITS-1:0] thresh_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic prep;
        logic tempo;
        logic rd_en;
        logic exec;
        logic load_out;
    } cvs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic step_phase;
    } cvs_stat_t;

    // 8192 / (q + 10) for q = tempo / 100 in 0..10
    function automatic logic [PERIOD_BITS-1:0] period_lut(input logic [QUOT_BITS-1:0] q);
        logic [PERIOD_BITS-1:0] p;
        case (q)
            4'd0:    p = 10'd819;
            4'd1:    p = 10'd744;
            4'd2:    p = 10'd682;
            4'd3:    p = 10'd630;
            4'd4:    p = 10'd585;
            4'd5:    p = 10'd546;
            4'd6:    p = 10'd512;
            4'd7:    p = 10'd481;
            4'd8:    p = 10'd455;
            4'd9:    p = 10'd431;
            default: p = 10'd409;
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/cvs_stream_if.sv
// Valid/ready word channel with a typed payload.
// Payload types come from cvs_pkg at the point of instantiation.
interface cvs_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> hw/rtl/cvs_ctrl.sv
// Sequencing state machine for the step sequencer.
// Depends on cvs_pkg; drives cvs_datapath through command/status structs.
module cvs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             res_valid,
    input  logic             res_ready,
    output cvs_pkg::cvs_cmd_t cmd,
    input  cvs_pkg::cvs_stat_t stat
);
    import cvs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_TEMPO,
        ST_READ,
        ST_EXEC,
        ST_READ_NEXT,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg;
    logic   out_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = res_valid_reg;
    assign out_free   = !res_valid_reg || res_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && item_valid;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.tempo    = (state_reg == ST_TEMPO);
        cmd.rd_en    = (state_reg == ST_READ) || (state_reg == ST_READ_NEXT);
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_LOAD) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (item_valid)
                    state_next = ST_PREP;
            ST_PREP:
                if (stat.is_clear)
                    state_next = ST_READ_NEXT;
                else if (!stat.step_phase)
                    state_next = ST_TEMPO;
                else
                    state_next = ST_READ;
            ST_TEMPO:     state_next = ST_READ_NEXT;
            ST_READ:      state_next = ST_EXEC;
            ST_EXEC:      state_next = ST_READ_NEXT;
            ST_READ_NEXT: state_next = ST_LOAD;
            ST_LOAD:
                if (out_free)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

endmodule

>>> hw/rtl/cvs_datapath.sv
// Step sequencer datapath: pitch memory, position, lamps, tempo period, result word.
// Depends on cvs_pkg; sequenced by cvs_ctrl.
module cvs_datapath #(
    parameter int STEPS = cvs_pkg::STEPS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cvs_pkg::cvs_cmd_t  cmd,
    output cvs_pkg::cvs_stat_t stat,
    input  cvs_pkg::item_t     item_payload,
    input  logic               cfg_wr,
    input  cvs_pkg::thresh_t   cfg_data,
    output cvs_pkg::result_t   res_payload
);
    import cvs_pkg::*;

    localparam int PW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(STEPS - 1);

    item_t                     in_reg;
    thresh_t                   thr_reg;
    logic [PW-1:0]             pos_reg;
    logic                      phase_reg;
    logic                      played_reg;
    logic [1:0]                div_reg;
    logic [1:0]                lamp_reg;
    logic [PERIOD_BITS-1:0]    period_reg;
    logic [QUOT_BITS-1:0]      quot_reg;
    logic [KIND_BITS-1:0]      kind_reg;
    logic [SAMPLE_BITS-1:0]    dac_reg;
    logic [LED_BITS-1:0]       leds_reg;
    logic [STEPS-1:0]          vld_reg;
    logic [SAMPLE_BITS-1:0]    rd_data_reg;
    logic                      rd_vld_reg;
    result_t                   res_reg;

    logic [SAMPLE_BITS-1:0]    mem [STEPS];

    logic [TEMPO_PROD_BITS-1:0] tempo_prod;
    logic [SAMPLE_BITS-1:0]     rd_value;
    logic                       wr_en;

    assign stat.is_clear   = (in_reg.command == CMD_CLEAR);
    assign stat.step_phase = phase_reg;
    assign res_payload     = res_reg;

    assign tempo_prod = TEMPO_PROD_BITS'(in_reg.tempo_sample)
                      * TEMPO_PROD_BITS'(TEMPO_RECIP);
    assign rd_value   = rd_vld_reg ? rd_data_reg : '0;
    assign wr_en      = cmd.exec
                      && ((in_reg.mode == MODE_RECORD)
                       || ((in_reg.mode == MODE_REPLACE) && (in_reg.pitch_sample > thr_reg)));

    // input word, product, memory read data: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= item_payload;
        if (cmd.prep)
            quot_reg <= tempo_prod[TEMPO_RECIP_SHIFT +: QUOT_BITS];
        if (wr_en)
            mem[pos_reg] <= in_reg.pitch_sample;
        if (cmd.rd_en)
            rd_data_reg <= mem[pos_reg];
        if (cmd.load_out)
        begin
            res_reg.kind          <= kind_reg;
            res_reg.dac_value     <= dac_reg;
            res_reg.step_leds     <= leds_reg;
            res_reg.tick_period   <= period_reg;
            res_reg.next_pitch    <= rd_value;
            res_reg.step_position <= POS_OUT_BITS'(pos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESH_RESET;
            pos_reg    <= '0;
            phase_reg  <= 1'b0;
            played_reg <= 1'b0;
            div_reg    <= '0;
            lamp_reg   <= '0;
            period_reg <= PERIOD_RESET;
            kind_reg   <= KIND_TEMPO;
            dac_reg    <= '0;
            leds_reg   <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                thr_reg <= cfg_data;

            if (cmd.prep)
            begin
                dac_reg  <= '0;
                leds_reg <= '0;
                if (in_reg.command == CMD_CLEAR)
                begin
                    vld_reg  <= '0;
                    kind_reg <= KIND_CLEAR;
                end
                else if ((in_reg.mode == MODE_PLAY) && !played_reg)
                begin
                    // first play rewinds once
                    pos_reg    <= '0;
                    played_reg <= 1'b1;
                end
            end

            if (cmd.tempo)
            begin
                period_reg <= period_lut(quot_reg);
                kind_reg   <= KIND_TEMPO;
                phase_reg  <= 1'b0 ^ 1'b1;
            end

            if (cmd.rd_en)
                rd_vld_reg <= vld_reg[pos_reg];

            if (cmd.exec)
            begin
                kind_reg  <= KIND_STEP;
                phase_reg <= 1'b0;
                pos_reg   <= (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                if (in_reg.mode != MODE_IDLE)
                begin
                    if (div_reg == 2'd0)
                    begin
                        leds_reg <= LED_BITS'(1) << lamp_reg;
                        lamp_reg <= lamp_reg + 1'b1;
                    end
                    div_reg <= div_reg + 1'b1;
                end
                if ((in_reg.mode == MODE_REPLACE) || (in_reg.mode == MODE_PLAY))
                    dac_reg <= rd_value;
                if (wr_en)
                    vld_reg[pos_reg] <= 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/cv_step_sequencer_top.sv
// Top level of the 32-step pitch sequencer.
// Depends on cvs_pkg, cvs_stream_if, cvs_ctrl and cvs_datapath.
module cv_step_sequencer_top #(
    parameter int STEPS = cvs_pkg::STEPS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    cvs_stream_if.sink   item,
    cvs_stream_if.source result,
    cvs_stream_if.sink   cfg
);
    // Pitch step sequencer. Every word on item is either a timer tick
    // (command 0) or a clear of the pitch store (command 1), and gives
    // exactly one word on result. Ticks alternate between a tempo phase,
    // which recomputes tick_period as 8192 / (tempo_sample / 100 + 10),
    // and a step phase, which handles the current step by mode (idle,
    // record, replace, play) and then advances the position modulo STEPS.
    // The first play tick rewinds the position to zero once. Lamps move
    // one place every fourth non-idle step. next_pitch and step_position
    // always describe the position left behind by the word.
    //
    // A step word goes through prep, read, exec, read_next and load before
    // item.ready rises again, a tempo word through prep, tempo, read_next and
    // load, a clear word through prep, read_next and load; load waits while
    // result.ready stays low on a full output register. The single read port
    // of the pitch memory is read twice on a step: once at the current step,
    // once at the next. item is taken while an earlier result still waits in
    // the output register; only the next result load waits for it.
    //
    // Reset clears the pitch store at once through per-step valid bits, so
    // there is no clearing pass; a clear word does the same.
    // cfg is always ready and writes replace_threshold (reset 5); write it
    // only while the block is idle.

    import cvs_pkg::*;

    cvs_cmd_t  cmd;
    cvs_stat_t stat;

    assign cfg.ready = 1'b1;

    cvs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    cvs_datapath #(
        .STEPS (STEPS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item_payload (item.payload),
        .cfg_wr       (cfg.valid),
        .cfg_data     (cfg.payload),
        .res_payload  (result.payload)
    );

endmodule

>>> hw/rtl/cvs_checker.sv
// Port-level checks for cv_step_sequencer_top, attached by bind.
// Depends on cvs_pkg and cv_step_sequencer_top_macros.svh.
`include "cv_step_sequencer_top_macros.svh"

module cvs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             res_valid,
    input logic             res_ready,
    input cvs_pkg::result_t res_payload
);
    import cvs_pkg::*;

    // a stalled result word holds
    `CVS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload), "result word changed while stalled")

    // one word at a time: never accepted back to back
    `CVS_ASSERT_NEXT(a_item_gap, item_valid && item_ready, !item_ready, "item accepted back to back")

    // only step words drive the DAC or the lamps, and at most one lamp
    `CVS_ASSERT_NOW(a_non_step_quiet, res_valid && (res_payload.kind != KIND_STEP), (res_payload.dac_value == '0) && (res_payload.step_leds == '0), "non-step word drives DAC or lamps")
    `CVS_ASSERT_NOW(a_leds_onehot, res_valid, $onehot0(res_payload.step_leds), "more than one lamp lit")

    // a clear leaves every stored step at zero: the word reports next_pitch zero
    `CVS_ASSERT_NOW(a_clear_zero, res_valid && (res_payload.kind == KIND_CLEAR), res_payload.next_pitch == '0, "clear word reports non-zero pitch")

endmodule

bind cv_step_sequencer_top cvs_checker u_cvs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_payload (result.payload)
);

>>> tb/cv_step_sequencer_top_tb.sv
// Self-checking testbench for cv_step_sequencer_top: directed and random ticks with a
// cycle-free predictor of the sequencer held in a small result board class.
// Depends on cvs_pkg, cvs_stream_if and the cv_step_sequencer_top RTL.
module cv_step_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cvs_pkg::*;

    localparam int STEPS            = STEPS_DEFAULT;
    localparam int PERIOD_NUM       = 8192;   // 0x2000 over (tempo / 100 + 10)
    localparam int TEMPO_DIV        = 100;
    localparam int TEMPO_BIAS       = 10;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_BITS) - 1;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int HOLD_CYCLES      = 400;    // long receiver hold-off
    localparam int QUIET_LIMIT      = 4000;   // cycles with no word moving on any channel
    localparam int SETTLE_CYCLES    = 64;

    // ------------------------------------------------------------------
    // Clock, reset and channels
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cvs_stream_if #(.payload_t(item_t))   item_if ();
    cvs_stream_if #(.payload_t(result_t)) result_if ();
    cvs_stream_if #(.payload_t(thresh_t)) cfg_if ();

    cv_step_sequencer_top #(.STEPS(STEPS)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // ------------------------------------------------------------------
    // Sequencer predictor and the queue of results still awaited
    // ------------------------------------------------------------------
    class pitch_seq_board;
        thresh_t                threshold;
        logic [SAMPLE_BITS-1:0] pitch_mem [STEPS];
        int unsigned            pos;
        bit                     in_step_phase;
        bit [1:0]               lamp_div;
        bit [1:0]               lamp_idx;
        bit                     play_seen;
        logic [PERIOD_BITS-1:0] period;
        result_t                awaited_results [$];
        int                     mismatches;

        function new();
            threshold     = THRESH_RESET;
            foreach (pitch_mem[i])
                pitch_mem[i] = '0;
            pos           = 0;
            in_step_phase = 1'b0;
            lamp_div      = '0;
            lamp_idx      = '0;
            play_seen     = 1'b0;
            period        = PERIOD_RESET;
            mismatches    = 0;
        endfunction

        // advance the sequencer by one accepted word, queue what it should emit
        function void note_item(item_t it);
            result_t     r;
            int unsigned tempo;
            r = '0;
            if (it.command == CMD_CLEAR)
            begin
                foreach (pitch_mem[i])
                    pitch_mem[i] = '0;
                r.kind = KIND_CLEAR;
            end
            else
            begin
                // first play ever rewinds to step 0, once per run
                if (it.mode == MODE_PLAY && !play_seen)
                begin
                    pos       = 0;
                    play_seen = 1'b1;
                end
                if (!in_step_phase)
                begin
                    tempo  = 32'(it.tempo_sample);
                    period = PERIOD_BITS'(PERIOD_NUM / (tempo / TEMPO_DIV + TEMPO_BIAS));
                    r.kind = KIND_TEMPO;
                end
                else
                begin
                    if (it.mode != MODE_IDLE)
                    begin
                        if (lamp_div == 2'd0)
                        begin
                            r.step_leds = LED_BITS'(1) << lamp_idx;
                            lamp_idx++;
                        end
                        lamp_div++;
                    end
                    case (it.mode)
                        MODE_RECORD:  pitch_mem[pos] = it.pitch_sample;
                        MODE_REPLACE:
                        begin
                            r.dac_value = pitch_mem[pos];
                            if (it.pitch_sample > threshold)
                                pitch_mem[pos] = it.pitch_sample;
                        end
                        MODE_PLAY:    r.dac_value = pitch_mem[pos];
                        default:      r.dac_value = '0;
                    endcase
                    pos    = (pos + 1 >= STEPS) ? 0 : pos + 1;
                    r.kind = KIND_STEP;
                end
                in_step_phase = !in_step_phase;
            end
            r.tick_period   = period;
            r.next_pitch    = pitch_mem[pos];
            r.step_position = POS_OUT_BITS'(pos);
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result word with nothing awaited, actual %h", $time, got);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind",          16'(want.kind),          16'(got.kind));
            compare_field("dac_value",     16'(want.dac_value),     16'(got.dac_value));
            compare_field("step_leds",     16'(want.step_leds),     16'(got.step_leds));
            compare_field("tick_period",   16'(want.tick_period),   16'(got.tick_period));
            compare_field("next_pitch",    16'(want.next_pitch),    16'(got.next_pitch));
            compare_field("step_position", 16'(want.step_position), 16'(got.step_position));
        endfunction
    endclass

    pitch_seq_board board = new();

    // Both channels are watched at the rising edge; an input word is noted before
    // a result is checked so a same-edge pass-through would still line up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
                board.note_item(item_if.payload);
            if (result_if.valid && result_if.ready)
                board.check_result(result_if.payload);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    int                   burst_left = 0;
    bit                   hold_req   = 1'b0;   // asks the receiver for the long hold-off
    logic [MODE_BITS-1:0] seg_mode   = MODE_IDLE;
    int                   seg_left   = 0;

    // Offer one word. Between bursts the sender idles for a random gap; an eager
    // word skips that so the block can be pushed until it stalls its input.
    task automatic send_word(item_t it, bit eager);
        int gap;
        if (!eager && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk) item_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do
            @(posedge clk);
        while (!item_if.ready);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid straight after the last word, then let the block empty out.
    task automatic wait_drained();
        @(negedge clk) item_if.valid <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only ever issued with nothing in flight.
    task automatic write_threshold(thresh_t value);
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        board.threshold = value;
        @(negedge clk) cfg_if.valid <= 1'b0;
    endtask

    function automatic item_t make_item(logic cmd, logic [MODE_BITS-1:0] mode,
                                        int pitch, int tempo);
        item_t it;
        it.command      = cmd;
        it.mode         = mode;
        it.pitch_sample = SAMPLE_BITS'(pitch);
        it.tempo_sample = SAMPLE_BITS'(tempo);
        return it;
    endfunction

    // Modes are held for runs of words (record a pattern, then play or replace
    // over it), with a sprinkling of odd modes and clears as noise.
    function automatic item_t random_item();
        item_t it;
        int    r;
        if (seg_left == 0)
        begin
            seg_left = $urandom_range(4, 40);
            r        = $urandom_range(0, 99);
            seg_mode = (r < 15) ? MODE_IDLE : (r < 45) ? MODE_RECORD :
                       (r < 75) ? MODE_REPLACE : MODE_PLAY;
        end
        seg_left--;
        it.command = ($urandom_range(0, 29) == 0) ? CMD_CLEAR : CMD_TICK;
        it.mode    = ($urandom_range(0, 9) == 0) ? MODE_BITS'($urandom_range(0, 3)) : seg_mode;
        case ($urandom_range(0, 7))
            0:       it.pitch_sample = board.threshold + SAMPLE_BITS'($urandom_range(0, 2)) - 1'b1;
            1:       it.pitch_sample = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
            default: it.pitch_sample = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
        // tempo near a multiple of 100 lands on the quotient steps
        if ($urandom_range(0, 4) == 0)
            it.tempo_sample = SAMPLE_BITS'(TEMPO_DIV * $urandom_range(1, 10) - $urandom_range(0, 1));
        else
            it.tempo_sample = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        return it;
    endfunction

    task automatic run_random(int count, bit with_hold);
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == 20)
                hold_req = 1'b1;
            send_word(random_item(), with_hold && i >= 20 && i < 60);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: runs of ready, stalls, random and toggling patterns, plus the
    // long hold-off on request, counted here in cycles.
    // ------------------------------------------------------------------
    initial
    begin
        int run_len;
        int style;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk) result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                run_len = $urandom_range(1, 16);
                style   = $urandom_range(0, 4);
                repeat (run_len)
                begin
                    @(negedge clk);
                    case (style)
                        0, 1:    result_if.ready <= 1'b1;
                        2:       result_if.ready <= 1'b0;
                        3:       result_if.ready <= 1'($urandom_range(0, 1));
                        default: result_if.ready <= ~result_if.ready;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no word moving anywhere ends the run.
    // ------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_if.valid && item_if.ready) ||
                (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("cv_step_sequencer_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed part at the reset threshold (5). Phases alternate tempo/step
        // from reset, so tick words pair up as tempo word then step word.
        send_word(make_item(CMD_TICK,  MODE_IDLE,    0,    0), 1'b0);      // slowest period
        send_word(make_item(CMD_TICK,  MODE_IDLE,    1023, 0), 1'b0);      // idle step, no lamp
        send_word(make_item(CMD_TICK,  MODE_RECORD,  0,    1023), 1'b0);   // fastest period
        send_word(make_item(CMD_TICK,  MODE_RECORD,  1023, 99), 1'b0);     // record full scale
        send_word(make_item(CMD_TICK,  MODE_RECORD,  0,    99), 1'b0);     // just below a step
        send_word(make_item(CMD_TICK,  MODE_RECORD,  0,    100), 1'b0);    // record zero
        send_word(make_item(CMD_TICK,  MODE_RECORD,  6,    100), 1'b0);
        send_word(make_item(CMD_TICK,  MODE_RECORD,  6,    999), 1'b0);    // record just over 5
        send_word(make_item(CMD_TICK,  MODE_REPLACE, 0,    1000), 1'b0);
        send_word(make_item(CMD_TICK,  MODE_REPLACE, 5,    1000), 1'b0);   // at threshold: kept
        send_word(make_item(CMD_TICK,  MODE_REPLACE, 0,    550), 1'b0);
        send_word(make_item(CMD_TICK,  MODE_REPLACE, 1023, 550), 1'b0);    // over: overwritten
        send_word(make_item(CMD_CLEAR, MODE_PLAY,    1023, 1023), 1'b0);   // clear skips rewind
        send_word(make_item(CMD_TICK,  MODE_PLAY,    0,    300), 1'b0);    // first play rewinds
        send_word(make_item(CMD_TICK,  MODE_PLAY,    0,    300), 1'b0);
        send_word(make_item(CMD_TICK,  MODE_RECORD,  512,  700), 1'b0);
        send_word(make_item(CMD_TICK,  MODE_RECORD,  512,  700), 1'b0);
        send_word(make_item(CMD_CLEAR, MODE_IDLE,    0,    0), 1'b0);      // clear in tempo phase
        send_word(make_item(CMD_TICK,  MODE_PLAY,    0,    42), 1'b0);
        send_word(make_item(CMD_TICK,  MODE_PLAY,    0,    42), 1'b0);     // plays a cleared step
        send_word(make_item(CMD_TICK,  MODE_REPLACE, 4,    0), 1'b0);
        send_word(make_item(CMD_CLEAR, MODE_RECORD,  1023, 1023), 1'b0);   // clear in step phase
        send_word(make_item(CMD_TICK,  MODE_REPLACE, 4,    0), 1'b0);      // under threshold
        wait_drained();

        // Random phases across thresholds, extremes included; the sender pauses
        // for a full drain before each register write.
        write_threshold('0);
        run_random(RANDOM_PER_PHASE, 1'b0);
        wait_drained();

        write_threshold(thresh_t'(SAMPLE_MAX));   // replace never overwrites
        run_random(RANDOM_PER_PHASE, 1'b0);
        wait_drained();

        write_threshold(thresh_t'($urandom_range(1, SAMPLE_MAX - 1)));
        run_random(RANDOM_PER_PHASE, 1'b0);
        wait_drained();

        // last phase carries the long receiver hold-off with an eager sender
        write_threshold(THRESH_RESET);
        run_random(RANDOM_PER_PHASE, 1'b1);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.awaited_results.size() == 0)
            $display("cv_step_sequencer_top verification clean");
        else
            $display("cv_step_sequencer_top verification failed");
        $finish;
    end

endmodule
